FILE: design/rwcc_pkg.sv
// Shared types, constants and character-table functions for the random word
// to character block. No dependencies.
`default_nettype none

package rwcc_pkg;

    localparam int WORD_W     = 64;
    localparam int CHAR_W     = 7;
    localparam int MASK_W     = 4;
    localparam int LEN_W      = 8;
    localparam int IDX_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int MAX_LENGTH = 128;
    localparam int POS_W      = $clog2(MAX_LENGTH);
    localparam int EFF_W      = $clog2(MAX_LENGTH + 1);
    localparam int CNT_W      = (EFF_W > LEN_W) ? EFF_W : LEN_W;
    localparam int DIV_STEPS  = WORD_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] REG_CHARSET_MASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANDOM_LIMIT  = 2'd2;

    localparam logic [MASK_W-1:0] MASK_RESET   = 4'hF;
    localparam logic [LEN_W-1:0]  LENGTH_RESET = 8'd20;
    localparam logic [WORD_W-1:0] LIMIT_RESET  = '1;

    localparam logic [IDX_W-1:0] N_LOWER  = 7'd26;
    localparam logic [IDX_W-1:0] N_UPPER  = 7'd26;
    localparam logic [IDX_W-1:0] N_DIGIT  = 7'd10;
    localparam logic [IDX_W-1:0] N_SYMBOL = 7'd32;

    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 7'h30;

    localparam logic [CHAR_W-1:0] SYMBOL_TABLE [32] = '{
        7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h26, 7'h27, 7'h28,
        7'h29, 7'h2A, 7'h2B, 7'h2C, 7'h2D, 7'h2E, 7'h2F, 7'h3A,
        7'h3B, 7'h3C, 7'h3D, 7'h3E, 7'h3F, 7'h40, 7'h5B, 7'h5C,
        7'h5D, 7'h5E, 7'h5F, 7'h60, 7'h7B, 7'h7C, 7'h7D, 7'h7E
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic div_start;
        logic div_sel_item;
        logic load_quantum;
        logic clear_quantum;
        logic capture_word;
        logic decide;
        logic load_out;
    } rwcc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic set_empty;
        logic direct;
        logic div_done;
        logic out_free;
    } rwcc_status_t;

    // Number of characters selected by the mask.
    function automatic logic [IDX_W-1:0] set_count(input logic [MASK_W-1:0] mask);
        logic [IDX_W-1:0] n;
        n = '0;
        if (mask[0]) n = n + N_LOWER;
        if (mask[1]) n = n + N_UPPER;
        if (mask[2]) n = n + N_DIGIT;
        if (mask[3]) n = n + N_SYMBOL;
        return n;
    endfunction

    // Walks the enabled sets in order and returns the character at idx.
    function automatic logic [CHAR_W-1:0] char_lookup(input logic [MASK_W-1:0] mask,
                                                      input logic [IDX_W-1:0]  idx);
        logic [IDX_W-1:0]  i;
        logic [CHAR_W-1:0] c;
        logic              found;
        i     = idx;
        c     = '0;
        found = 1'b0;
        if (mask[0]) begin
            if (i < N_LOWER) begin
                c     = CHAR_LOWER_A + i;
                found = 1'b1;
            end else begin
                i = i - N_LOWER;
            end
        end
        if (mask[1] && !found) begin
            if (i < N_UPPER) begin
                c     = CHAR_UPPER_A + i;
                found = 1'b1;
            end else begin
                i = i - N_UPPER;
            end
        end
        if (mask[2] && !found) begin
            if (i < N_DIGIT) begin
                c     = CHAR_DIGIT_0 + i;
                found = 1'b1;
            end else begin
                i = i - N_DIGIT;
            end
        end
        if (mask[3] && !found && (i < N_SYMBOL)) begin
            c = SYMBOL_TABLE[i[4:0]];
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: design/rwcc_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on rwcc_pkg.
`default_nettype none

module rwcc_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [rwcc_pkg::WORD_W-1:0] dividend,
    input  wire logic [rwcc_pkg::WORD_W-1:0] divisor,
    output logic                             done,
    output logic [rwcc_pkg::WORD_W-1:0]      quotient,
    output logic [rwcc_pkg::WORD_W-1:0]      remainder
);
    import rwcc_pkg::*;

    logic [WORD_W-1:0] rem_reg, quo_reg, den_reg;
    logic [WORD_W-1:0] rem_next, quo_next;
    logic [STEP_W-1:0] cnt_reg;
    logic              run_reg, done_reg;
    logic [WORD_W:0]   shifted, trial;
    logic              fits;

    always_comb begin
        shifted  = {rem_reg, quo_reg[WORD_W-1]};
        trial    = shifted - {1'b0, den_reg};
        fits     = !trial[WORD_W];
        rem_next = fits ? trial[WORD_W-1:0] : shifted[WORD_W-1:0];
        quo_next = {quo_reg[WORD_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(DIV_STEPS - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end else if (run_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

FILE: design/rwcc_datapath.sv
// Datapath: configuration registers, range-reduction constants, divider,
// position counter and the output register. Depends on rwcc_pkg, rwcc_div.
`default_nettype none

module rwcc_datapath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [rwcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rwcc_pkg::WORD_W-1:0]    cfg_data,
    input  wire logic [rwcc_pkg::WORD_W-1:0]    s_random_word,
    input  wire rwcc_pkg::rwcc_cmd_t            cmd,
    output rwcc_pkg::rwcc_status_t              status,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [rwcc_pkg::CHAR_W-1:0]         m_character,
    output logic                                m_last_of_string,
    output logic                                m_no_set_error
);
    import rwcc_pkg::*;

    logic [MASK_W-1:0] mask_reg;
    logic [LEN_W-1:0]  length_reg;
    logic [WORD_W-1:0] limit_reg;
    logic [WORD_W-1:0] quantum_reg, red_limit_reg;
    logic [WORD_W-1:0] word_reg;
    logic              direct_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              m_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg, err_reg;

    logic [IDX_W-1:0]  n_chars;
    logic              set_empty, direct;
    logic [WORD_W-1:0] div_dividend, div_divisor, div_quo, div_rem;
    logic              div_done;
    logic [IDX_W-1:0]  idx;
    logic [CNT_W-1:0]  len_ext, len_eff, pos_plus;
    logic              last;

    assign n_chars   = set_count(mask_reg);
    assign set_empty = (n_chars == '0);
    assign direct    = set_empty || (quantum_reg == '0) || (word_reg >= red_limit_reg);

    // One division of the limit by N yields q directly; L is the limit less the remainder.
    assign div_dividend = cmd.div_sel_item ? word_reg : limit_reg;
    assign div_divisor  = cmd.div_sel_item ? quantum_reg : WORD_W'(n_chars);

    rwcc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        if (direct_reg || (div_quo >= WORD_W'(n_chars))) begin
            idx = n_chars - 1'b1;
        end else begin
            idx = div_quo[IDX_W-1:0];
        end
        len_ext = CNT_W'(length_reg);
        if (len_ext == '0) begin
            len_eff = CNT_W'(1);
        end else if (len_ext > CNT_W'(MAX_LENGTH)) begin
            len_eff = CNT_W'(MAX_LENGTH);
        end else begin
            len_eff = len_ext;
        end
        pos_plus = CNT_W'(pos_reg) + CNT_W'(1);
        last     = (pos_plus >= len_eff);
        pos_next = last ? '0 : pos_plus[POS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg      <= MASK_RESET;
            length_reg    <= LENGTH_RESET;
            limit_reg     <= LIMIT_RESET;
            quantum_reg   <= '0;
            red_limit_reg <= '0;
            pos_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_CHARSET_MASK:  mask_reg   <= cfg_data[MASK_W-1:0];
                    REG_OUTPUT_LENGTH: length_reg <= cfg_data[LEN_W-1:0];
                    REG_RANDOM_LIMIT:  limit_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.clear_quantum) begin
                quantum_reg   <= '0;
                red_limit_reg <= '0;
            end else if (cmd.load_quantum) begin
                quantum_reg   <= div_quo;
                red_limit_reg <= limit_reg - div_rem;
            end
            if (cmd.load_out && !set_empty) begin
                pos_reg <= pos_next;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture_word) begin
            word_reg <= s_random_word;
        end
        if (cmd.decide) begin
            direct_reg <= direct;
        end
        if (cmd.load_out) begin
            char_reg <= set_empty ? '0 : char_lookup(mask_reg, idx);
            last_reg <= set_empty ? 1'b0 : last;
            err_reg  <= set_empty;
        end
    end

    assign status.set_empty = set_empty;
    assign status.direct    = direct;
    assign status.div_done  = div_done;
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid          = m_valid_reg;
    assign m_character      = char_reg;
    assign m_last_of_string = last_reg;
    assign m_no_set_error   = err_reg;

endmodule

`default_nettype wire

FILE: design/rwcc_ctrl.sv
// Controller state machine: sequences the recompute after reset or a
// register write, and each word through the divider when it needs a division. Depends on rwcc_pkg.
`default_nettype none

module rwcc_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire rwcc_pkg::rwcc_status_t status,
    output rwcc_pkg::rwcc_cmd_t         cmd
);
    import rwcc_pkg::*;

    localparam logic [2:0] ST_CSTART = 3'd0;
    localparam logic [2:0] ST_CDIV   = 3'd1;
    localparam logic [2:0] ST_IDLE   = 3'd2;
    localparam logic [2:0] ST_ISTART = 3'd3;
    localparam logic [2:0] ST_IDIV   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CSTART: begin
                if (status.set_empty) begin
                    cmd.clear_quantum = 1'b1;
                    state_next        = ST_IDLE;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_CDIV;
                end
            end
            ST_CDIV: begin
                if (status.div_done) begin
                    cmd.load_quantum = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready          = 1'b1;
                cmd.capture_word = 1'b1;
                if (s_valid) begin
                    state_next = ST_ISTART;
                end
            end
            ST_ISTART: begin
                cmd.decide = 1'b1;
                if (status.direct) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.div_start    = 1'b1;
                    cmd.div_sel_item = 1'b1;
                    state_next       = ST_IDIV;
                end
            end
            ST_IDIV: begin
                if (status.div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CSTART;
            end
        endcase
        // A register write always restarts the recompute.
        if (cfg_we) begin
            state_next = ST_CSTART;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CSTART;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/random_word_to_charset_char_top.sv
// Random word to character-set character: top level.
// Each accepted word goes through the 64-step serial divider unless no division
// is needed; the block takes no new word until the current one has reached the
// output register. Reset, and every register write, start a recompute of the
// range-reduction constants, with s_ready low while it runs (the divider is
// skipped when the mask selects no set).
`default_nettype none

module random_word_to_charset_char_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration write port.
    input  wire logic                           cfg_we,
    input  wire logic [rwcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rwcc_pkg::WORD_W-1:0]    cfg_data,
    // Input word channel.
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [rwcc_pkg::WORD_W-1:0]    s_random_word,
    // Result word channel.
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [rwcc_pkg::CHAR_W-1:0]         m_character,
    output logic                                m_last_of_string,
    output logic                                m_no_set_error
);
    import rwcc_pkg::*;

    // The controller and the datapath talk only through these two bundles.
    rwcc_cmd_t    cmd;
    rwcc_status_t status;

    // The controller walks each word through capture, a decision on whether
    // a division is needed, the division itself and the final table lookup.
    // A finished result sits in the output register, so the next word can be
    // accepted while the previous result still waits to be taken.
    rwcc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_we  (cfg_we),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds the registers, the shared divider (used once per
    // non-empty recompute for the quantum and the reduced limit, and once per
    // word that needs it for the table index) and the position counter.
    rwcc_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_random_word    (s_random_word),
        .cmd              (cmd),
        .status           (status),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_character      (m_character),
        .m_last_of_string (m_last_of_string),
        .m_no_set_error   (m_no_set_error)
    );

endmodule

`default_nettype wire
